>>> rtl/ntwr_pkg.sv
// ----------------------------------------------------------------------------
// ntwr_pkg: shared definitions for the nearest target within range block
// Field widths, register indexes, command codes and reset values.
// ----------------------------------------------------------------------------
package ntwr_pkg;

    // Field widths of the stream payloads
    localparam int FIELD_COORD_W = 12;
    localparam int INDEX_W       = 8;
    localparam int REACH_W       = 12;
    localparam int TICKS_W       = 16;
    localparam int DIST_W        = 25;
    localparam int REACH_SQ_W    = 2 * REACH_W;

    // Stream and configuration port widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Default for the coordinate datapath width
    localparam int COORD_BITS_DEF = 12;

    // Register reset values
    localparam logic [REACH_W-1:0]    REACH_RST    = 12'd100;
    localparam logic [TICKS_W-1:0]    COOLDOWN_RST = 16'd30;
    localparam logic [REACH_SQ_W-1:0] REACH_SQ_RST = 24'd10000;
    localparam logic [TICKS_W-1:0]    TICKS_MAX    = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_REACH    = 2'd2,
        CFG_COOLDOWN = 2'd3
    } cfg_index_t;

    // Input command codes and result kinds
    localparam logic CMD_SCAN   = 1'b0;
    localparam logic CMD_SHOOT  = 1'b1;
    localparam logic KIND_SCAN  = 1'b0;
    localparam logic KIND_SHOOT = 1'b1;

endpackage

>>> rtl/nearest_target_within_range.sv
// ----------------------------------------------------------------------------
// nearest_target_within_range: nearest live object search with fire control
// Scans objects for the nearest live one within reach, latches it as the
// target at the end of a scan, and decides on each shoot tick whether to fire.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  s_*     | in        | s_tvalid/s_tready  | tdata, tlast = scan_last, tuser
//  m_*     | out       | m_tvalid/m_tready  | tdata, tuser = result_kind
//  cfg_*   | in        | cfg_we             | cfg_index, cfg_data
//
//  One item per cycle while the output is not stalled: an accepted transfer
//  lands in the input register and is evaluated once the output slot is free
//  or draining (two squares, an add and a compare against the running best);
//  a shoot tick or the end of a scan loads a result into the output register.
//  A stalled output holds its result; the input register still takes one
//  more transfer and then holds until the output drains.
//  rst_n clears all control state asynchronously; no clearing pass is needed.
//
module nearest_target_within_range #(
    parameter int COORD_BITS = ntwr_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [11:0] obj_x, [23:12] obj_y, [24] obj_alive, [32:25] obj_index, zero pad
    input  logic [ntwr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    // [0] command
    input  logic                             s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] target_found, [8:1] target_index, [9] fired, zero pad
    output logic [ntwr_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] result_kind
    output logic                             m_tuser,

    input  logic                             cfg_we,
    input  logic [ntwr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ntwr_pkg::CFG_DAT_W-1:0]   cfg_data
);

    // Coordinate bits that survive both the field width and COORD_BITS
    localparam int CW = (COORD_BITS < ntwr_pkg::FIELD_COORD_W) ?
                        COORD_BITS : ntwr_pkg::FIELD_COORD_W;
    localparam int FW = ntwr_pkg::FIELD_COORD_W;
    localparam int IW = ntwr_pkg::INDEX_W;
    localparam int DW = ntwr_pkg::DIST_W;
    localparam int TW = ntwr_pkg::TICKS_W;
    localparam int RW = ntwr_pkg::REACH_W;
    localparam int QW = ntwr_pkg::REACH_SQ_W;

    // Configuration registers
    logic [CW-1:0] origin_x_reg;
    logic [CW-1:0] origin_y_reg;
    logic [RW-1:0] reach_reg;
    logic [QW-1:0] reach_sq_reg;
    logic [TW-1:0] cooldown_reg;

    // Search and target state
    logic [DW-1:0] best_dist_reg, best_dist_next;
    logic [IW-1:0] best_index_reg, best_index_next;
    logic          best_valid_reg, best_valid_next;
    logic [IW-1:0] held_index_reg, held_index_next;
    logic          held_valid_reg, held_valid_next;
    logic [TW-1:0] ticks_reg, ticks_next;

    // Input register
    logic          in_valid_reg;
    logic          in_cmd_reg;
    logic [FW-1:0] in_x_reg;
    logic [FW-1:0] in_y_reg;
    logic          in_alive_reg;
    logic [IW-1:0] in_index_reg;
    logic          in_last_reg;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg, out_kind_next;
    logic          out_found_reg, out_found_next;
    logic [IW-1:0] out_index_reg, out_index_next;
    logic          out_fired_reg, out_fired_next;

    logic          advance;
    logic          out_load;
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    logic [2*CW-1:0] dx_sq;
    logic [2*CW-1:0] dy_sq;
    logic [DW-1:0] sq_dist;
    logic [QW-1:0] cfg_reach_sq;
    logic [TW-1:0] ticks_inc;
    logic          in_reach;

    // Evaluate the held item when the output slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Absolute offsets and squared distance to the origin
    always_comb
    begin
        if (in_x_reg[CW-1:0] >= origin_x_reg)
        begin
            dx = in_x_reg[CW-1:0] - origin_x_reg;
        end
        else
        begin
            dx = origin_x_reg - in_x_reg[CW-1:0];
        end
        if (in_y_reg[CW-1:0] >= origin_y_reg)
        begin
            dy = in_y_reg[CW-1:0] - origin_y_reg;
        end
        else
        begin
            dy = origin_y_reg - in_y_reg[CW-1:0];
        end
        dx_sq   = dx * dx;
        dy_sq   = dy * dy;
        sq_dist = DW'(dx_sq) + DW'(dy_sq);
    end

    assign cfg_reach_sq = cfg_data[RW-1:0] * cfg_data[RW-1:0];
    assign ticks_inc    = (ticks_reg == ntwr_pkg::TICKS_MAX) ? ticks_reg
                                                             : ticks_reg + 1'b1;
    assign in_reach     = (sq_dist <= DW'(reach_sq_reg));

    // Next state of the search, the target and the result
    always_comb
    begin
        best_dist_next  = best_dist_reg;
        best_index_next = best_index_reg;
        best_valid_next = best_valid_reg;
        held_index_next = held_index_reg;
        held_valid_next = held_valid_reg;
        ticks_next      = ticks_reg;
        out_load        = 1'b0;
        out_kind_next   = out_kind_reg;
        out_found_next  = out_found_reg;
        out_index_next  = out_index_reg;
        out_fired_next  = out_fired_reg;

        if (advance)
        begin
            if (in_cmd_reg == ntwr_pkg::CMD_SCAN)
            begin
                // Keep the nearest live object; a tie goes to the later one
                if (in_alive_reg && (sq_dist <= best_dist_reg))
                begin
                    best_dist_next  = sq_dist;
                    best_index_next = in_index_reg;
                    best_valid_next = 1'b1;
                end
                // Latch the target and rearm the search at the end of a scan
                if (in_last_reg)
                begin
                    held_valid_next = best_valid_next;
                    held_index_next = best_valid_next ? best_index_next : '0;
                    best_dist_next  = DW'(reach_sq_reg);
                    best_index_next = '0;
                    best_valid_next = 1'b0;
                    out_load        = 1'b1;
                    out_kind_next   = ntwr_pkg::KIND_SCAN;
                    out_found_next  = held_valid_next;
                    out_index_next  = held_index_next;
                    out_fired_next  = 1'b0;
                end
            end
            else
            begin
                // Shoot tick: advance the cooldown, fire or drop the target
                ticks_next     = ticks_inc;
                out_fired_next = 1'b0;
                if (held_valid_reg && in_alive_reg && in_reach)
                begin
                    if (ticks_inc >= cooldown_reg)
                    begin
                        ticks_next     = '0;
                        out_fired_next = 1'b1;
                    end
                end
                else
                begin
                    held_valid_next = 1'b0;
                    held_index_next = '0;
                end
                out_load       = 1'b1;
                out_kind_next  = ntwr_pkg::KIND_SHOOT;
                out_found_next = held_valid_next;
                out_index_next = held_index_next;
            end
        end

        // Reload the search bound on a reach write while nothing qualified
        if (cfg_we && (cfg_index == ntwr_pkg::CFG_REACH) && !best_valid_reg)
        begin
            best_dist_next = DW'(cfg_reach_sq);
        end

        // Output slot: load a new result, or drop the one just transferred
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            reach_reg    <= ntwr_pkg::REACH_RST;
            reach_sq_reg <= ntwr_pkg::REACH_SQ_RST;
            cooldown_reg <= ntwr_pkg::COOLDOWN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ntwr_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data[CW-1:0];
                ntwr_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data[CW-1:0];
                ntwr_pkg::CFG_REACH:
                begin
                    reach_reg    <= cfg_data[RW-1:0];
                    reach_sq_reg <= cfg_reach_sq;
                end
                ntwr_pkg::CFG_COOLDOWN: cooldown_reg <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // Search, target and output control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_dist_reg  <= DW'(ntwr_pkg::REACH_SQ_RST);
            best_index_reg <= '0;
            best_valid_reg <= 1'b0;
            held_index_reg <= '0;
            held_valid_reg <= 1'b0;
            ticks_reg      <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            best_dist_reg  <= best_dist_next;
            best_index_reg <= best_index_next;
            best_valid_reg <= best_valid_next;
            held_index_reg <= held_index_next;
            held_valid_reg <= held_valid_next;
            ticks_reg      <= ticks_next;
            out_valid_reg  <= out_valid_next;
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
        end
    end

    // Input payload: capture on each transfer
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg   <= s_tuser;
            in_x_reg     <= s_tdata[FW-1:0];
            in_y_reg     <= s_tdata[2*FW-1:FW];
            in_alive_reg <= s_tdata[2*FW];
            in_index_reg <= s_tdata[2*FW+IW:2*FW+1];
            in_last_reg  <= s_tlast;
        end
    end

    // Output payload: hold until the next result
    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
        out_fired_reg <= out_fired_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(ntwr_pkg::M_TDATA_W - IW - 2){1'b0}},
                       out_fired_reg, out_index_reg, out_found_reg};

    // Reach register is only kept for its square; tie it to the square
    a_reach_sq: assert property (@(posedge clk) disable iff (!rst_n)
        (reach_sq_reg == QW'(reach_reg * reach_reg)))
        else $error("reach square out of step with reach");

    // A fire clears the cooldown counter
    a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_fired_next) |=> (ticks_reg == '0))
        else $error("counter not cleared after fire");

    // No target held means index zero
    a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid_reg |-> (held_index_reg == '0))
        else $error("held index set without a target");

    // An item waiting on a stalled output stays in the input register
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_index_reg)))
        else $error("input item lost during stall");

endmodule
